// File: rtl/fesk_pkg.sv
// Shared types and constants for the FIFO-evicting key set.
package fesk_pkg;

    // Key geometry: four 64-bit words form one 256-bit key.
    localparam int WORD_W = 64;
    localparam int KEY_W  = 4 * WORD_W;

    // Default number of stored entries.
    localparam int DEF_CAPACITY = 64;

    // Command codes carried by an input transaction.
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_RESP
    } t_state;

    // Result of one command.
    typedef struct packed {
        logic found;
        logic evicted;
    } t_result;

endpackage

// File: rtl/fesk_if.sv
// Valid/ready channel interfaces for commands and results.
interface fesk_cmd_if;
    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [fesk_pkg::WORD_W-1:0] key_word0;
    logic [fesk_pkg::WORD_W-1:0] key_word1;
    logic [fesk_pkg::WORD_W-1:0] key_word2;
    logic [fesk_pkg::WORD_W-1:0] key_word3;

    modport source (output valid, command, key_word0, key_word1, key_word2, key_word3,
                    input ready);
    modport sink   (input valid, command, key_word0, key_word1, key_word2, key_word3,
                    output ready);
endinterface

interface fesk_rsp_if;
    logic valid;
    logic ready;
    logic found;
    logic evicted;

    modport source (output valid, found, evicted, input ready);
    modport sink   (input valid, found, evicted, output ready);
endinterface

// File: rtl/fesk_key_mem.sv
// Key storage: one write port, one read port with registered read data.
module fesk_key_mem #(
    parameter int CAPACITY = fesk_pkg::DEF_CAPACITY,
    parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [fesk_pkg::KEY_W-1:0] i_wr_data,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [fesk_pkg::KEY_W-1:0] o_rd_data
);

    logic [fesk_pkg::KEY_W-1:0] r_mem [CAPACITY];
    logic [fesk_pkg::KEY_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/fesk_seq.sv
// Sequencer: keeps entries in age order in a circular buffer, scans and compacts it.
module fesk_seq #(
    parameter int CAPACITY = fesk_pkg::DEF_CAPACITY,
    parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Command side
    input  logic                       i_acc,
    input  fesk_pkg::t_cmd             i_cmd,
    input  logic [fesk_pkg::KEY_W-1:0] i_key,
    output logic                       o_ready,
    // Result side
    input  logic                       i_res_free,
    output logic                       o_res_load,
    output fesk_pkg::t_result          o_res,
    // Key memory
    output logic                       o_we,
    output logic [AW-1:0]              o_wr_addr,
    output logic [fesk_pkg::KEY_W-1:0] o_wr_data,
    output logic                       o_re,
    output logic [AW-1:0]              o_rd_addr,
    input  logic [fesk_pkg::KEY_W-1:0] i_rd_data
);

    localparam int SW = CW + 1;

    fesk_pkg::t_state           r_state, n_state;
    logic [AW-1:0]              r_head, n_head;
    logic [CW-1:0]              r_count, n_count;
    logic [AW-1:0]              r_age, n_age;
    logic                       r_iss_vld, n_iss_vld;
    logic                       r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]              r_cmp_age, n_cmp_age;
    logic [fesk_pkg::KEY_W-1:0] r_key, n_key;
    logic                       r_found, n_found;
    logic                       r_evicted, n_evicted;

    logic          w_full;
    logic          w_empty;
    logic [AW-1:0] w_last;
    logic          w_hit;
    logic          w_cmp_last;

    // Physical slot of an age position: base plus age, wrapped once.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [CW-1:0] age);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(age);
        if (sum >= SW'(CAPACITY)) begin
            sum = sum - SW'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    // Shared status and the single key comparator.
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_last     = AW'(r_count - CW'(1));
    assign w_hit      = r_cmp_vld && (i_rd_data == r_key);
    assign w_cmp_last = (r_cmp_age == w_last);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            fesk_pkg::ST_IDLE: begin
                if (i_acc) begin
                    if (i_cmd == fesk_pkg::CMD_REMOVE && !w_empty) begin
                        n_state = fesk_pkg::ST_SCAN;
                    end else begin
                        n_state = fesk_pkg::ST_RESP;
                    end
                end
            end
            fesk_pkg::ST_SCAN: begin
                if (w_hit) begin
                    n_state = w_cmp_last ? fesk_pkg::ST_RESP : fesk_pkg::ST_SHIFT;
                end else if (r_cmp_vld && r_cmp_age == '0) begin
                    n_state = fesk_pkg::ST_RESP;
                end
            end
            fesk_pkg::ST_SHIFT: begin
                if (r_cmp_vld && w_cmp_last) begin
                    n_state = fesk_pkg::ST_RESP;
                end
            end
            fesk_pkg::ST_RESP: begin
                if (i_res_free) begin
                    n_state = fesk_pkg::ST_IDLE;
                end
            end
            default: n_state = fesk_pkg::ST_IDLE;
        endcase
    end

    // Datapath: pointer updates, memory accesses and result bits.
    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_age     = r_age;
        n_iss_vld = r_iss_vld;
        n_cmp_vld = r_cmp_vld;
        n_cmp_age = r_cmp_age;
        n_key     = r_key;
        n_found   = r_found;
        n_evicted = r_evicted;
        o_we      = 1'b0;
        o_wr_addr = phys(r_head, r_count);
        o_wr_data = i_key;
        o_re      = 1'b0;
        o_rd_addr = phys(r_head, CW'(r_age));
        case (r_state)
            fesk_pkg::ST_IDLE: begin
                if (i_acc) begin
                    n_key     = i_key;
                    n_found   = 1'b0;
                    n_evicted = 1'b0;
                    if (i_cmd == fesk_pkg::CMD_INSERT) begin
                        // The newest position; when full it lands on the oldest slot.
                        o_we = 1'b1;
                        if (w_full) begin
                            n_head    = phys(r_head, CW'(1));
                            n_evicted = 1'b1;
                        end else begin
                            n_count = r_count + CW'(1);
                        end
                    end else if (!w_empty) begin
                        n_age     = w_last;
                        n_iss_vld = 1'b1;
                        n_cmp_vld = 1'b0;
                    end
                end
            end
            fesk_pkg::ST_SCAN: begin
                // Read from newest toward oldest, compare in the cycle after the read.
                o_re      = r_iss_vld;
                n_cmp_vld = r_iss_vld;
                n_cmp_age = r_age;
                if (r_iss_vld) begin
                    if (r_age == '0) begin
                        n_iss_vld = 1'b0;
                    end else begin
                        n_age = r_age - AW'(1);
                    end
                end
                if (w_hit) begin
                    n_found   = 1'b1;
                    n_cmp_vld = 1'b0;
                    if (w_cmp_last) begin
                        n_count   = r_count - CW'(1);
                        n_iss_vld = 1'b0;
                    end else begin
                        n_age     = r_cmp_age + AW'(1);
                        n_iss_vld = 1'b1;
                    end
                end
            end
            fesk_pkg::ST_SHIFT: begin
                // Move each newer entry down by one age position.
                o_re      = r_iss_vld;
                n_cmp_vld = r_iss_vld;
                n_cmp_age = r_age;
                if (r_iss_vld) begin
                    if (r_age == w_last) begin
                        n_iss_vld = 1'b0;
                    end else begin
                        n_age = r_age + AW'(1);
                    end
                end
                if (r_cmp_vld) begin
                    o_we      = 1'b1;
                    o_wr_addr = phys(r_head, CW'(r_cmp_age - AW'(1)));
                    o_wr_data = i_rd_data;
                    if (w_cmp_last) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            fesk_pkg::ST_RESP: begin
                n_iss_vld = 1'b0;
                n_cmp_vld = 1'b0;
            end
            default: begin
                n_iss_vld = 1'b0;
                n_cmp_vld = 1'b0;
            end
        endcase
    end

    // Handshake outputs.
    always_comb begin
        o_ready       = (r_state == fesk_pkg::ST_IDLE);
        o_res_load    = (r_state == fesk_pkg::ST_RESP) && i_res_free;
        o_res.found   = r_found;
        o_res.evicted = r_evicted;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fesk_pkg::ST_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_iss_vld <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_iss_vld <= n_iss_vld;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_age     <= n_age;
        r_cmp_age <= n_cmp_age;
        r_key     <= n_key;
        r_found   <= n_found;
        r_evicted <= n_evicted;
    end

`ifndef NO_ASSERTIONS
    // The entry count never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // An insert into a table with room grows the count by one.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && i_cmd == fesk_pkg::CMD_INSERT && !w_full)
        |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the count");

    // The search never writes the key memory.
    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fesk_pkg::ST_SCAN) |-> !o_we)
        else $error("memory write during search");

    // A remove that hits the newest entry leaves one entry fewer.
    a_found_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fesk_pkg::ST_SCAN && w_hit && w_cmp_last)
        |=> r_count == $past(r_count) - CW'(1))
        else $error("hit on newest entry did not shrink the count");
`endif

endmodule

// File: rtl/fifo_evicting_key_set_unit.sv
// Insert: key written on acceptance, then the result register loaded once free.
// Remove: one key compare per cycle on the memory read port while searching
// newest to oldest, then one entry moved per cycle to close the gap.
// One command is in flight at a time; the result register frees the command side.
// Synchronous active-low reset empties the set at once; no clearing pass.
module fifo_evicting_key_set_unit #(
    parameter int CAPACITY = fesk_pkg::DEF_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fesk_cmd_if.sink   i_cmd,
    fesk_rsp_if.source o_rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic                       w_ready;
    logic                       w_acc;
    logic [fesk_pkg::KEY_W-1:0] w_key;
    logic                       w_res_free;
    logic                       w_res_load;
    fesk_pkg::t_result          w_res;
    logic                       w_we;
    logic [AW-1:0]              w_wr_addr;
    logic [fesk_pkg::KEY_W-1:0] w_wr_data;
    logic                       w_re;
    logic [AW-1:0]              w_rd_addr;
    logic [fesk_pkg::KEY_W-1:0] w_rd_data;

    logic              r_out_valid;
    fesk_pkg::t_result r_out_res;

    // Command transaction.
    assign i_cmd.ready = w_ready;
    assign w_acc       = i_cmd.valid && w_ready;
    assign w_key       = {i_cmd.key_word3, i_cmd.key_word2, i_cmd.key_word1, i_cmd.key_word0};

    fesk_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (w_acc),
        .i_cmd      (fesk_pkg::t_cmd'(i_cmd.command)),
        .i_key      (w_key),
        .o_ready    (w_ready),
        .i_res_free (w_res_free),
        .o_res_load (w_res_load),
        .o_res      (w_res),
        .o_we       (w_we),
        .o_wr_addr  (w_wr_addr),
        .o_wr_data  (w_wr_data),
        .o_re       (w_re),
        .o_rd_addr  (w_rd_addr),
        .i_rd_data  (w_rd_data)
    );

    fesk_key_mem #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_key_mem (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_re      (w_re),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Result register: free when empty or being taken this cycle.
    assign w_res_free = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_out_res <= w_res;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.found   = r_out_res.found;
    assign o_rsp.evicted = r_out_res.evicted;

`ifndef NO_ASSERTIONS
    // A new result is only loaded when the register is free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_load |-> (!r_out_valid || o_rsp.ready))
        else $error("result overwritten before transaction");

    // A result never reports both found and evicted.
    a_insert_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_load |-> !(w_res.found && w_res.evicted))
        else $error("result reports both found and evicted");

    // Commands are only taken while no result is being produced.
    a_accept_not_loading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> !w_res_load)
        else $error("command accepted while loading a result");
`endif

endmodule
